@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sweep scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("assertion failed");

// Property must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("assertion failed");

`endif

@@ design/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Types and constants shared by the stepper sweep range scanner.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 16;
  localparam int LEG_W      = 12;
  localparam int INTV_W     = 9;
  localparam int ASTEP_W    = 10;
  localparam int ANGLE_W    = 10;
  localparam int PHASE_W    = 3;
  localparam int COIL_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int MODC_W     = $clog2(LEG_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEPS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd6;

  // Register reset values
  localparam logic [LEG_W-1:0]   RST_SWEEP_STEPS  = 12'd1024;
  localparam logic [INTV_W-1:0]  RST_SAMPLE_INTV  = 9'd16;
  localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT   = 16'd48;
  localparam logic [DIST_W-1:0]  RST_FAR_LIMIT    = 16'd1920;
  localparam logic [DIST_W-1:0]  RST_FILL_VALUE   = 16'd1600;
  localparam logic [DIST_W-1:0]  RST_DETECT_LIMIT = 16'd1600;
  localparam logic [ASTEP_W-1:0] RST_ANGLE_STEP   = 10'd281;

  // floor(x / 100) = (x * ceil(2^25 / 100)) >> 25, exact for x < 493447
  localparam int                 RECIP_W      = 19;
  localparam logic [RECIP_W-1:0] RECIP_DIV100 = 19'd335545;
  localparam int                 RECIP_SHIFT  = 25;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 10'd1023;

  // Item action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Run mode
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_REWIND  = 2'd1,
    MODE_FORWARD = 2'd2,
    MODE_RETURN  = 2'd3
  } run_mode_t;

  // Reported status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_FOUND   = 3'd2,
    ST_NONE    = 3'd3,
    ST_ABORTED = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture item, arm remainder unit
    logic mod_run;   // one remainder iteration
    logic exec;      // apply item to sweep state
    logic scan_run;  // one arg-min scan step
    logic mul1;      // index * angle step
    logic mul2;      // reciprocal multiply
    logic fin;       // commit report
    logic push;      // load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_done;
    logic scan_req;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/sss_if.sv @@
// ----------------------------------------------------------------------------
// sss_if
// Valid/ready channel interfaces for sweep items and results.
// ----------------------------------------------------------------------------
interface sss_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [sss_pkg::DIST_W-1:0] distance_q4;
  logic                      abort;

  modport source (output valid, output action, output distance_q4, output abort,
                  input ready);
  modport sink   (input valid, input action, input distance_q4, input abort,
                  output ready);
endinterface

interface sss_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sss_pkg::COIL_W-1:0]   coils;
  logic                         busy_res;
  logic [sss_pkg::STATUS_W-1:0] status;
  logic                         sample_taken;
  logic [sss_pkg::DIST_W-1:0]   min_distance_q4;
  logic [sss_pkg::ANGLE_W-1:0]  angle_deg;

  modport source (output valid, output coils, output busy_res, output status,
                  output sample_taken, output min_distance_q4, output angle_deg,
                  input ready);
  modport sink   (input valid, input coils, input busy_res, input status,
                  input sample_taken, input min_distance_q4, input angle_deg,
                  output ready);
endinterface

@@ design/sss_ram.sv @@
// ----------------------------------------------------------------------------
// sss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sss_ctrl.sv @@
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer: accepts an item, runs the remainder unit, applies the step,
// walks the sample store for the arg-min and scales the angle when the return leg reaches home, pushes a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output sss_pkg::dp_cmd_t  cmd,
  input  sss_pkg::dp_stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MOD  = 8'b0000_0010,
    S_EXEC = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_PUSH = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_ready && req_valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_MOD;
      S_MOD:  if (stat.mod_done) state_next = S_EXEC;
      S_EXEC: state_next = stat.scan_req ? S_SCAN : S_PUSH;
      S_SCAN: if (stat.scan_done) state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_FIN;
      S_FIN:  state_next = S_PUSH;
      S_PUSH: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.mod_run  = (state == S_MOD);
    cmd.exec     = (state == S_EXEC);
    cmd.scan_run = (state == S_SCAN);
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.fin      = (state == S_FIN);
    cmd.push     = (state == S_PUSH) && stat.out_free;
  end

  `ASSERT_NEXT(a_accept_to_mod, clk, rst, accept, state == S_MOD)
  `ASSERT_NEXT(a_push_to_idle, clk, rst, cmd.push, state == S_IDLE)
  `ASSERT_SAME(a_one_stage, clk, rst, 1'b1,
               $onehot0({cmd.mod_run, cmd.exec, cmd.scan_run, cmd.fin, cmd.push}))

endmodule

@@ design/sss_dp.sv @@
// ----------------------------------------------------------------------------
// sss_dp
// Sweep datapath: configuration registers, motor and leg state, remainder
// unit for the sample cadence, sample store, arg-min scan, angle scaling
// and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sss_dp #(
  parameter int NUM_SAMPLES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_action,
  input  logic [sss_pkg::DIST_W-1:0]     req_distance_q4,
  input  logic                           req_abort,
  input  sss_pkg::dp_cmd_t               cmd,
  output sss_pkg::dp_stat_t              stat,
  sss_rsp_if.source                      rsp
);

  localparam int IW  = $clog2(NUM_SAMPLES);
  localparam int SIW = $clog2(NUM_SAMPLES + 1);
  localparam int PW  = IW + sss_pkg::ASTEP_W;
  localparam int QW  = PW + sss_pkg::RECIP_W;

  localparam int DW = sss_pkg::DIST_W;
  localparam int LW = sss_pkg::LEG_W;
  localparam int NW = sss_pkg::INTV_W;

  // Configuration registers
  logic [LW-1:0]                   sweep_steps;
  logic [NW-1:0]                   sample_interval;
  logic [DW-1:0]                   near_limit, far_limit, fill_value, detect_limit;
  logic [sss_pkg::ASTEP_W-1:0]     angle_step;

  // Sweep state
  sss_pkg::run_mode_t              run_mode, mode_next;
  logic [sss_pkg::PHASE_W-1:0]     coil_phase, phase_next;
  logic [LW-1:0]                   position, position_next;
  logic [LW-1:0]                   leg_step, leg_step_next;
  logic [SIW-1:0]                  sample_index, sample_index_next;
  logic                            coils_on, coils_on_next;
  sss_pkg::status_t                held_status, status_next;
  logic [DW-1:0]                   reported_min;
  logic [sss_pkg::ANGLE_W-1:0]     reported_angle;
  logic [NUM_SAMPLES-1:0]          entry_valid;

  // Captured item
  logic                            it_action, it_abort;
  logic [DW-1:0]                   it_dist;

  // Remainder unit
  logic [NW-1:0]                   mod_rem;
  logic [LW-1:0]                   mod_bits;
  logic [sss_pkg::MODC_W-1:0]      mod_cnt;
  logic [NW:0]                     mod_trial;

  // Step evaluation
  logic [LW-1:0]                   steps;
  logic [NW-1:0]                   interval;
  logic                            taken, taken_q, scan_flag;
  logic                            mem_we;
  logic [IW-1:0]                   slot;
  logic [DW-1:0]                   mem_wdata, mem_rdata;

  // Scan and angle
  logic [IW-1:0]                   scan_addr, data_idx, best_idx;
  logic                            data_live, rd_vld, stopped;
  logic [DW-1:0]                   best, scan_val;
  logic [PW-1:0]                   prod1;
  logic [QW-1:0]                   prod2, ang_full;
  logic [sss_pkg::ANGLE_W-1:0]     ang_sat;

  logic [sss_pkg::COIL_W-1:0]      coils_val;
  logic                            rsp_valid;

  function automatic logic [sss_pkg::PHASE_W-1:0] step_cw(
    input logic [sss_pkg::PHASE_W-1:0] ph);
    step_cw = (ph >= 3'd4) ? 3'd1 : ph + 3'd1;
  endfunction

  function automatic logic [sss_pkg::PHASE_W-1:0] step_ccw(
    input logic [sss_pkg::PHASE_W-1:0] ph);
    step_ccw = (ph == 3'd0 || ph > 3'd4) ? 3'd4 : ph - 3'd1;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_steps     <= sss_pkg::RST_SWEEP_STEPS;
      sample_interval <= sss_pkg::RST_SAMPLE_INTV;
      near_limit      <= sss_pkg::RST_NEAR_LIMIT;
      far_limit       <= sss_pkg::RST_FAR_LIMIT;
      fill_value      <= sss_pkg::RST_FILL_VALUE;
      detect_limit    <= sss_pkg::RST_DETECT_LIMIT;
      angle_step      <= sss_pkg::RST_ANGLE_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_SWEEP_STEPS:  sweep_steps     <= cfg_data[LW-1:0];
        sss_pkg::CFG_SAMPLE_INTV:  sample_interval <= cfg_data[NW-1:0];
        sss_pkg::CFG_NEAR_LIMIT:   near_limit      <= cfg_data[DW-1:0];
        sss_pkg::CFG_FAR_LIMIT:    far_limit       <= cfg_data[DW-1:0];
        sss_pkg::CFG_FILL_VALUE:   fill_value      <= cfg_data[DW-1:0];
        sss_pkg::CFG_DETECT_LIMIT: detect_limit    <= cfg_data[DW-1:0];
        sss_pkg::CFG_ANGLE_STEP:   angle_step      <= cfg_data[sss_pkg::ASTEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign steps    = (sweep_steps == '0) ? LW'(1) : sweep_steps;
  assign interval = (sample_interval == '0) ? NW'(1) : sample_interval;

  // Item capture and leg_step mod interval, one bit per cycle
  assign mod_trial = {mod_rem, mod_bits[LW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_action <= req_action;
      it_dist   <= req_distance_q4;
      it_abort  <= req_abort;
      mod_rem   <= '0;
      mod_bits  <= leg_step;
      mod_cnt   <= '0;
    end else if (cmd.mod_run) begin
      mod_rem  <= (mod_trial >= {1'b0, interval}) ? NW'(mod_trial - {1'b0, interval})
                                                  : mod_trial[NW-1:0];
      mod_bits <= {mod_bits[LW-2:0], 1'b0};
      mod_cnt  <= mod_cnt + 1'b1;
    end
  end

  assign stat.mod_done = (mod_cnt == sss_pkg::MODC_W'(LW - 1));

  // Store slot saturates at the last entry
  assign slot = (sample_index < SIW'(NUM_SAMPLES)) ? sample_index[IW-1:0]
                                                   : IW'(NUM_SAMPLES - 1);
  assign mem_wdata = (near_limit < it_dist && it_dist < far_limit) ? it_dist : fill_value;

  // Apply one item to the sweep state
  always_comb begin
    mode_next         = run_mode;
    phase_next        = coil_phase;
    position_next     = position;
    leg_step_next     = leg_step;
    sample_index_next = sample_index;
    coils_on_next     = coils_on;
    status_next       = held_status;
    taken             = 1'b0;
    scan_flag         = 1'b0;
    if (it_action == sss_pkg::ACT_START) begin
      sample_index_next = '0;
      leg_step_next     = '0;
      mode_next   = (position == '0) ? sss_pkg::MODE_FORWARD : sss_pkg::MODE_REWIND;
      status_next = sss_pkg::ST_RUNNING;
    end else begin
      case (run_mode)
        sss_pkg::MODE_REWIND: begin
          position_next = position - 1'b1;
          if (position_next != '0) begin
            phase_next    = step_ccw(coil_phase);
            coils_on_next = 1'b1;
          end else begin
            mode_next = sss_pkg::MODE_FORWARD;
          end
        end
        sss_pkg::MODE_FORWARD: begin
          position_next = position + 1'b1;
          if (mod_rem == '0) begin
            taken = 1'b1;
            if (sample_index < SIW'(NUM_SAMPLES)) begin
              sample_index_next = sample_index + 1'b1;
            end
          end
          if (it_abort) begin
            mode_next   = sss_pkg::MODE_IDLE;
            status_next = sss_pkg::ST_ABORTED;
          end else begin
            phase_next    = step_cw(coil_phase);
            coils_on_next = 1'b1;
            leg_step_next = leg_step + 1'b1;
            if (leg_step_next >= steps) begin
              leg_step_next = '0;
              mode_next     = sss_pkg::MODE_RETURN;
            end
          end
        end
        sss_pkg::MODE_RETURN: begin
          if (it_abort) begin
            coils_on_next = 1'b0;
            mode_next     = sss_pkg::MODE_IDLE;
            status_next   = sss_pkg::ST_ABORTED;
          end else begin
            position_next = position - 1'b1;
            if (position_next != '0) begin
              phase_next    = step_ccw(coil_phase);
              coils_on_next = 1'b1;
            end
            leg_step_next = leg_step + 1'b1;
            if (position_next == '0 || leg_step_next >= steps) begin
              coils_on_next = 1'b0;
              mode_next     = sss_pkg::MODE_IDLE;
              if (position_next == '0) begin
                scan_flag = 1'b1;
              end else begin
                status_next = sss_pkg::ST_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.scan_req = scan_flag;
  assign mem_we        = cmd.exec && taken;

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= sss_pkg::MODE_IDLE;
      coil_phase     <= '0;
      position       <= '0;
      leg_step       <= '0;
      sample_index   <= '0;
      coils_on       <= 1'b0;
      held_status    <= sss_pkg::ST_IDLE;
      reported_min   <= '0;
      reported_angle <= '0;
      entry_valid    <= '0;
      taken_q        <= 1'b0;
    end else begin
      if (cmd.exec) begin
        run_mode     <= mode_next;
        coil_phase   <= phase_next;
        position     <= position_next;
        leg_step     <= leg_step_next;
        sample_index <= sample_index_next;
        coils_on     <= coils_on_next;
        held_status  <= status_next;
        taken_q      <= taken;
      end
      if (mem_we) begin
        entry_valid[slot] <= 1'b1;
      end
      // Arg-min result
      if (cmd.fin) begin
        if (best < detect_limit) begin
          reported_min   <= best;
          reported_angle <= ang_sat;
          held_status    <= sss_pkg::ST_FOUND;
        end else begin
          held_status    <= sss_pkg::ST_NONE;
        end
      end
    end
  end

  sss_ram #(.WIDTH(DW), .DEPTH(NUM_SAMPLES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  // Arg-min walk; entries never written read as zero
  assign scan_val       = rd_vld ? mem_rdata : '0;
  assign stat.scan_done = data_live && (data_idx == IW'(NUM_SAMPLES - 1));

  always_ff @(posedge clk) begin
    rd_vld <= entry_valid[scan_addr];
    if (cmd.exec) begin
      scan_addr <= '0;
      data_live <= 1'b0;
      stopped   <= 1'b0;
    end else if (cmd.scan_run) begin
      scan_addr <= scan_addr + 1'b1;
      data_idx  <= scan_addr;
      data_live <= 1'b1;
      if (data_live) begin
        if (data_idx == '0) begin
          best     <= scan_val;
          best_idx <= '0;
        end else if (!stopped && scan_val < best) begin
          if (scan_val == '0) begin
            stopped <= 1'b1;
          end else begin
            best     <= scan_val;
            best_idx <= data_idx;
          end
        end
      end
    end
  end

  // Angle: floor(index * step / 100), saturated
  assign ang_full = prod2 >> sss_pkg::RECIP_SHIFT;
  assign ang_sat  = (ang_full > QW'(sss_pkg::ANGLE_MAX)) ? sss_pkg::ANGLE_MAX
                                                          : ang_full[sss_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1 <= PW'(best_idx) * PW'(angle_step);
    end
    if (cmd.mul2) begin
      prod2 <= QW'(prod1) * QW'(sss_pkg::RECIP_DIV100);
    end
  end

  // Output register
  always_comb begin
    coils_val = '0;
    if (coils_on) begin
      case (coil_phase)
        3'd1:    coils_val = 4'b0001;
        3'd2:    coils_val = 4'b0010;
        3'd3:    coils_val = 4'b0100;
        3'd4:    coils_val = 4'b1000;
        default: coils_val = '0;
      endcase
    end
  end

  assign stat.out_free = !rsp_valid || rsp.ready;
  assign rsp.valid     = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.coils           <= coils_val;
      rsp.busy_res        <= (run_mode != sss_pkg::MODE_IDLE);
      rsp.status          <= held_status;
      rsp.sample_taken    <= taken_q;
      rsp.min_distance_q4 <= reported_min;
      rsp.angle_deg       <= reported_angle;
    end
  end

  `ASSERT_SAME(a_index_cap, clk, rst, 1'b1, sample_index <= SIW'(NUM_SAMPLES))
  `ASSERT_SAME(a_coils_wave, clk, rst, 1'b1, $onehot0(coils_val))
  `ASSERT_NEXT(a_home_stops, clk, rst, cmd.exec && scan_flag,
               run_mode == sss_pkg::MODE_IDLE && !coils_on && position == '0)

endmodule

@@ design/stepper_sweep_range_scanner.sv @@
// ----------------------------------------------------------------------------
// stepper_sweep_range_scanner
// Sweep controller for a four-phase wave-drive stepper with range sampling
// and an end-of-sweep arg-min over the stored samples.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | handshake
//  req     | in  | action, distance_q4, abort                   | valid/ready
//  rsp     | out | coils, busy_res, status, sample_taken,       | valid/ready
//          |     | min_distance_q4, angle_deg                   |
//  cfg     | in  | cfg_index, cfg_data                          | cfg_we
//
// Each item is accepted, then run through the bit-serial remainder of the leg count
// by the sample interval; the step is then applied and the result pushed.
// A tick that brings the return leg home also runs the arg-min walk over the
// store (one RAM read per cycle) and then the angle scaling before the push.
// Reset clears the store through per-entry valid bits; there is no clearing pass.
// A stalled result waits in the output register; the next item is taken once
// the result has been loaded there.
// ----------------------------------------------------------------------------
module stepper_sweep_range_scanner #(
  parameter int NUM_SAMPLES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
  sss_req_if.sink                        req,
  sss_rsp_if.source                      rsp
);

  sss_pkg::dp_cmd_t  cmd;
  sss_pkg::dp_stat_t stat;
  logic              ready;

  assign req.ready = ready;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sss_dp #(.NUM_SAMPLES(NUM_SAMPLES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_action      (req.action),
    .req_distance_q4 (req.distance_q4),
    .req_abort       (req.abort),
    .cmd             (cmd),
    .stat            (stat),
    .rsp             (rsp)
  );

endmodule
